// ===== design/ccu_pkg.sv =====
package ccu_pkg;

    localparam int CCU_MAX_LENGTH = 32;
    localparam int CCU_COEF_W     = 30;
    localparam int CCU_ROWS       = 32;
    localparam int CCU_QDEPTH     = 2;
    localparam int CCU_QPTR_W     = $clog2(CCU_QDEPTH);
    localparam int CCU_QCNT_W     = $clog2(CCU_QDEPTH + 1);

    typedef logic [CCU_COEF_W-1:0] t_coef;
    typedef t_coef [0:CCU_ROWS-1]  t_row;
    typedef t_row [0:CCU_ROWS-1]   t_tab;

    typedef enum logic [1:0] {
        K_WALK = 2'd0,
        K_ZERO = 2'd1,
        K_FULL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [5:0]  len;
        logic [5:0]  ones;
        logic [4:0]  m0;
        logic [4:0]  m1;
        logic [29:0] rank;
        t_kind       kind;
    } t_job;

    typedef struct packed {
        logic take;
        logic load;
    } t_back_stat;

    // pascal triangle, entries with k above n stay zero
    function automatic t_tab build_tab();
        t_tab tab;
        tab = '0;
        for (int n = 0; n < CCU_ROWS; n++) begin
            for (int k = 0; k < CCU_ROWS; k++) begin
                if (k == 0) begin
                    tab[n][k] = t_coef'(1);
                end else if (n > 0) begin
                    tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
                end
            end
        end
        return tab;
    endfunction

    localparam t_tab CCU_BINOM_TAB = build_tab();

    // bits lo up to hi-1 set
    function automatic logic [31:0] fill_mask(logic [5:0] lo, logic [5:0] hi);
        logic [31:0] m;
        for (int i = 0; i < 32; i++) begin
            m[i] = (6'(i) >= lo) && (6'(i) < hi);
        end
        return m;
    endfunction

endpackage

// ===== design/ccu_front.sv =====
module ccu_front #(
    parameter int MAX_LENGTH = ccu_pkg::CCU_MAX_LENGTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [5:0]    i_length,
    input  logic [5:0]    i_ones,
    input  logic [4:0]    i_first_mark,
    input  logic [4:0]    i_second_mark,
    input  logic [29:0]   i_rank,
    output logic          o_job_valid,
    output ccu_pkg::t_job o_job,
    input  logic          i_take
);
    import ccu_pkg::*;

    t_job                  r_q [0:CCU_QDEPTH-1];
    logic [CCU_QPTR_W-1:0] r_wp, n_wp;
    logic [CCU_QPTR_W-1:0] r_rp, n_rp;
    logic [CCU_QCNT_W-1:0] r_cnt, n_cnt;
    logic                  s_wr;
    logic                  s_rd;
    logic [5:0]            s_len;
    t_job                  s_job;

    // saturate length and sort out the trivial transactions
    always_comb begin
        s_len = (i_length > 6'(MAX_LENGTH)) ? 6'(MAX_LENGTH) : i_length;
        s_job.len  = s_len;
        s_job.ones = i_ones;
        s_job.m0   = i_first_mark;
        s_job.m1   = i_second_mark;
        s_job.rank = i_rank;
        if (s_len == 6'd0 || i_ones == 6'd0) begin
            s_job.kind = K_ZERO;
        end else if (i_ones >= s_len) begin
            s_job.kind = K_FULL;
        end else begin
            s_job.kind = K_WALK;
        end
    end

    assign o_full      = (r_cnt == CCU_QCNT_W'(CCU_QDEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign s_wr        = i_push && !o_full;
    assign s_rd        = i_take && o_job_valid;

    always_comb begin
        n_wp  = s_wr ? r_wp + 1'b1 : r_wp;
        n_rp  = s_rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (s_wr && !s_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (s_rd && !s_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wp] <= s_job;
        end
    end

endmodule

// ===== design/ccu_back.sv =====
module ccu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  ccu_pkg::t_job       i_job,
    input  logic                i_pop,
    output logic                o_res_valid,
    output logic [31:0]         o_res_mask,
    output ccu_pkg::t_back_stat o_stat
);
    import ccu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_STEP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_len, n_len;
    logic [5:0]  r_left, n_left;
    logic [4:0]  r_m0, n_m0;
    logic [4:0]  r_m1, n_m1;
    logic [29:0] r_rank, n_rank;
    logic [31:0] r_mask, n_mask;
    logic        r_marked, n_marked;
    logic        r_res_valid, n_res_valid;
    logic [31:0] r_res_mask;
    t_row        r_row_a, n_row_a;
    t_row        r_row_b, n_row_b;

    logic [5:0]  s_q;
    logic [5:0]  s_rest;
    logic [1:0]  s_ahead;
    logic [5:0]  s_sub;
    logic [5:0]  s_avail;
    t_coef       s_ca;
    t_coef       s_cb;
    t_coef       s_zc;
    logic        s_take;
    logic        s_load;

    // binomial rows for the position decided in the next cycle
    always_comb begin
        s_q     = (r_state == S_PREP) ? r_pos : r_pos + 6'd1;
        s_rest  = r_len - s_q - 6'd1;
        s_ahead = {1'b0, ({1'b0, r_m0} > s_q)} + {1'b0, ({1'b0, r_m1} > s_q)};
        s_sub   = s_rest - {4'b0, s_ahead};
        n_row_a = CCU_BINOM_TAB[s_rest[4:0]];
        n_row_b = (s_rest < {4'b0, s_ahead}) ? '0 : CCU_BINOM_TAB[s_sub[4:0]];
    end

    always_comb begin
        s_avail = r_len - r_pos;
        s_ca    = r_left[5] ? '0 : r_row_a[r_left[4:0]];
        s_cb    = r_left[5] ? '0 : r_row_b[r_left[4:0]];
        s_zc    = r_marked ? s_ca : s_ca - s_cb;
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_len    = r_len;
        n_left   = r_left;
        n_m0     = r_m0;
        n_m1     = r_m1;
        n_rank   = r_rank;
        n_mask   = r_mask;
        n_marked = r_marked;
        s_take   = 1'b0;
        s_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    s_take   = 1'b1;
                    n_pos    = '0;
                    n_len    = i_job.len;
                    n_left   = i_job.ones;
                    n_m0     = i_job.m0;
                    n_m1     = i_job.m1;
                    n_rank   = i_job.rank;
                    n_marked = 1'b0;
                    case (i_job.kind)
                        K_ZERO: begin
                            n_mask  = '0;
                            n_state = S_DONE;
                        end
                        K_FULL: begin
                            n_mask  = fill_mask(6'd0, i_job.len);
                            n_state = S_DONE;
                        end
                        default: begin
                            n_mask  = '0;
                            n_state = S_PREP;
                        end
                    endcase
                end
            end
            S_PREP: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_pos == r_len || r_left == 6'd0) begin
                    n_state = S_DONE;
                end else if (r_left == s_avail) begin
                    n_mask  = r_mask | fill_mask(r_pos, r_len);
                    n_state = S_DONE;
                end else begin
                    n_pos = r_pos + 6'd1;
                    if (r_rank >= s_zc) begin
                        n_rank              = r_rank - s_zc;
                        n_mask[r_pos[4:0]]  = 1'b1;
                        n_left              = r_left - 6'd1;
                        if (r_pos[4:0] == r_m0 || r_pos[4:0] == r_m1) begin
                            n_marked = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_pop) begin
                    s_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (s_load) begin
            n_res_valid = 1'b1;
        end else if (i_pop) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_left   <= n_left;
        r_m0     <= n_m0;
        r_m1     <= n_m1;
        r_rank   <= n_rank;
        r_mask   <= n_mask;
        r_marked <= n_marked;
        if (r_state == S_PREP || r_state == S_STEP) begin
            r_row_a <= n_row_a;
            r_row_b <= n_row_b;
        end
        if (s_load) begin
            r_res_mask <= r_mask;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_mask  = r_res_mask;
    assign o_stat.take = s_take;
    assign o_stat.load = s_load;

endmodule

// ===== design/constrained_combination_unrank_core.sv =====
// channel   | direction | handshake          | fields
// ----------+-----------+--------------------+--------------------------------------------
// request   | in        | push / full        | i_length i_ones i_first_mark i_second_mark
//           |           |                    | i_rank
// result    | out       | empty / pop        | o_support
//
// a request with zero length, zero ones or ones not below length skips the walk
// and goes from idle to done; any other walks one bit position per cycle through the
// binomial row registers until it is done.
// a two-entry queue in front and a result register at the back take new
// transactions while the walk runs or a result waits for pop.
// reset clears queue pointers, walk state and result valid; nothing is pending after it.
module constrained_combination_unrank_core #(
    parameter int MAX_LENGTH = ccu_pkg::CCU_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  i_length,
    input  logic [5:0]  i_ones,
    input  logic [4:0]  i_first_mark,
    input  logic [4:0]  i_second_mark,
    input  logic [29:0] i_rank,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_support
);
    import ccu_pkg::*;

    logic       s_job_valid;
    t_job       s_job;
    t_back_stat s_stat;
    logic       s_res_valid;
    logic       s_pop;

    assign empty = !s_res_valid;
    assign s_pop = pop && s_res_valid;

    ccu_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_length      (i_length),
        .i_ones        (i_ones),
        .i_first_mark  (i_first_mark),
        .i_second_mark (i_second_mark),
        .i_rank        (i_rank),
        .o_job_valid   (s_job_valid),
        .o_job         (s_job),
        .i_take        (s_stat.take)
    );

    ccu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_job_valid),
        .i_job       (s_job),
        .i_pop       (s_pop),
        .o_res_valid (s_res_valid),
        .o_res_mask  (o_support),
        .o_stat      (s_stat)
    );

    a_take_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.take |-> s_job_valid)
        else $error("back took a transaction from an empty queue");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.load |-> (empty || pop))
        else $error("result register overwritten while a result waits");

    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> s_job_valid)
        else $error("accepted transaction did not reach the queue");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending right after reset");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_LEN     = ccu_pkg::CCU_MAX_LENGTH;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        logic [5:0]  length;
        logic [5:0]  ones;
        logic [4:0]  first_mark;
        logic [4:0]  second_mark;
        logic [29:0] rank;
        bit          known;
        logic [31:0] known_support;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [5:0]  i_length = '0;
    logic [5:0]  i_ones = '0;
    logic [4:0]  i_first_mark = '0;
    logic [4:0]  i_second_mark = '0;
    logic [29:0] i_rank = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_support;

    // expectation attached to the request on the bus
    bit          req_known = 1'b0;
    logic [31:0] req_known_support = '0;

    logic [31:0] support_q[$];
    int          errors = 0;
    int          stall_cycles = 0;
    int          idle_pct = 12;
    bit          hold_armed = 1'b0;

    constrained_combination_unrank_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_length      (i_length),
        .i_ones        (i_ones),
        .i_first_mark  (i_first_mark),
        .i_second_mark (i_second_mark),
        .i_rank        (i_rank),
        .empty         (empty),
        .pop           (pop),
        .o_support     (o_support)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned choose(int n, int k);
        longint unsigned acc;
        acc = 1;
        if (n < 0 || k < 0 || k > n) begin
            return 0;
        end
        if (k > n - k) begin
            k = n - k;
        end
        for (int i = 1; i <= k; i++) begin
            acc = acc * longint'(n - k + i) / longint'(i);
        end
        return acc;
    endfunction

    function automatic logic [31:0] unrank_support(logic [5:0] len_in, logic [5:0] ones_in,
            logic [4:0] m0, logic [4:0] m1, logic [29:0] rank_in);
        int              len;
        int              left;
        int              avail;
        int              rest;
        int              ahead;
        longint unsigned r;
        longint unsigned zc;
        logic [31:0]     mask;
        bit              marked;
        len    = (int'(len_in) > MAX_LEN) ? MAX_LEN : int'(len_in);
        left   = int'(ones_in);
        r      = longint'(rank_in);
        mask   = '0;
        marked = 1'b0;
        for (int pos = 0; pos < len; pos++) begin
            avail = len - pos;
            if (left == 0) begin
                break;
            end
            if (left == avail) begin
                for (int b = pos; b < len; b++) begin
                    mask[b] = 1'b1;
                end
                break;
            end
            rest  = avail - 1;
            ahead = (int'(m0) > pos ? 1 : 0) + (int'(m1) > pos ? 1 : 0);
            zc    = choose(rest, left);
            if (!marked) begin
                zc = zc - choose(rest - ahead, left);
            end
            if (r >= zc) begin
                r         = r - zc;
                mask[pos] = 1'b1;
                left      = left - 1;
                if (pos == int'(m0) || pos == int'(m1)) begin
                    marked = 1'b1;
                end
            end
        end
        return mask;
    endfunction

    function automatic t_request make_req(int len, int ones, int m0, int m1, longint rank,
            bit known = 1'b0, logic [31:0] val = '0);
        t_request r;
        r.length        = 6'(len);
        r.ones          = 6'(ones);
        r.first_mark    = 5'(m0);
        r.second_mark   = 5'(m1);
        r.rank          = 30'(rank);
        r.known         = known;
        r.known_support = val;
        return r;
    endfunction

    // mostly well-formed: distinct marks in range, rank mostly within the valid count; a fifth are arbitrary
    function automatic t_request random_request();
        t_request        r;
        int              len;
        int              ones;
        int              m0;
        int              m1;
        longint unsigned count;
        if ($urandom_range(99) < 20) begin
            r = make_req($urandom_range(63), $urandom_range(63), $urandom_range(31),
                         $urandom_range(31), $urandom());
        end else begin
            len = $urandom_range(2, MAX_LEN);
            ones = $urandom_range(1, len - 1);
            m0 = $urandom_range(len - 1);
            m1 = $urandom_range(len - 2);
            if (m1 >= m0) begin
                m1 = m1 + 1;
            end
            count = choose(len, ones) - choose(len - 2, ones);
            case ($urandom_range(9))
                0: r = make_req(len, ones, m0, m1, count - 1);
                1: r = make_req(len, ones, m0, m1, count);
                default: r = make_req(len, ones, m0, m1, {$urandom(), $urandom()} % count);
            endcase
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push              <= 1'b1;
        i_length          <= r.length;
        i_ones            <= r.ones;
        i_first_mark      <= r.first_mark;
        i_second_mark     <= r.second_mark;
        i_rank            <= r.rank;
        req_known         <= r.known;
        req_known_support <= r.known_support;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // receiver, with one long hold-off once armed
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else begin
                pop <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // accepted transactions on both sides
    always @(posedge i_clk) begin
        logic [31:0] want;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                moved = 1'b1;
                if (req_known) begin
                    support_q.push_back(req_known_support);
                end else begin
                    support_q.push_back(unrank_support(i_length, i_ones, i_first_mark,
                                                       i_second_mark, i_rank));
                end
            end
            if (pop && !empty) begin
                moved = 1'b1;
                if (support_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, got support %h",
                             $time, o_support);
                end else begin
                    want = support_q.pop_front();
                    if (o_support !== want) begin
                        errors = errors + 1;
                        $display("%0t: support mismatch, expected %h, got %h",
                                 $time, want, o_support);
                    end
                end
            end
        end
        stall_cycles <= moved ? 0 : stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_request directed_q[$];
        directed_q = '{
            make_req(0, 5, 0, 1, 0, 1'b1, 32'h0),
            make_req(32, 0, 3, 9, 7, 1'b1, 32'h0),
            make_req(1, 0, 0, 1, 0, 1'b1, 32'h0),
            make_req(1, 1, 0, 1, 0, 1'b1, 32'h1),
            make_req(8, 8, 2, 5, 0, 1'b1, 32'h0000_00ff),
            make_req(8, 12, 2, 5, 3, 1'b1, 32'h0000_00ff),
            make_req(63, 32, 0, 31, 0, 1'b1, 32'hffff_ffff),
            make_req(63, 63, 31, 31, 30'h3fff_ffff, 1'b1, 32'hffff_ffff),
            make_req(32, 32, 31, 30, 30'h3fff_ffff, 1'b1, 32'hffff_ffff),
            make_req(4, 1, 0, 1, 0),
            make_req(4, 1, 0, 1, 1),
            make_req(2, 1, 0, 1, 0),
            make_req(2, 1, 0, 1, 1),
            make_req(10, 3, 4, 7, 30'h3fff_ffff),
            make_req(10, 3, 3, 3, 12),
            make_req(5, 2, 20, 31, 1),
            make_req(32, 16, 0, 31, 300000000),
            make_req(32, 16, 5, 17, 30'h3fff_ffff),
            make_req(32, 1, 31, 0, 1),
            make_req(32, 31, 15, 16, 0),
            make_req(33, 5, 1, 30, 1000),
            make_req(31, 15, 0, 30, 0)
        };
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            send_request(directed_q[i]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 350) begin
                hold_armed = 1'b1;
            end
            if (n == 450) begin
                idle_pct = 0;
            end
            if (n == 750) begin
                idle_pct = 12;
            end
            send_request(random_request());
        end
        push <= 1'b0;

        while (support_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && support_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
